@@ rtl/core/glw_pkg.sv @@
// Shared types, codes and saturation helpers for the word-wrap layout block.
package glw_pkg;

  // Character classes of an input code point; the unused code acts as a glyph.
  typedef enum logic [1:0] {
    CLS_GLYPH     = 2'd0,
    CLS_SPACE     = 2'd1,
    CLS_LINE_FEED = 2'd2
  } char_class_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH    = 2'd0,
    CFG_LINE_HEIGHT   = 2'd1,
    CFG_LINE_PADDING  = 2'd2,
    CFG_SPACE_ADVANCE = 2'd3
  } cfg_addr_t;

  localparam logic [15:0] LINE_WIDTH_RST = 16'hFFFF;
  localparam logic [15:0] LINE_INDEX_MAX = 16'hFFFF;
  localparam logic [23:0] U24_MAX       = 24'hFFFFFF;
  localparam logic [23:0] S24_MAX       = 24'h7FFFFF;
  localparam logic [23:0] S24_MIN       = 24'h800000;

  typedef struct packed {
    logic [1:0]         char_class;
    logic [15:0]        glyph_advance;
    logic signed [15:0] kerning_prev;
    logic               end_of_text;
  } glw_item_t;

  typedef struct packed {
    logic signed [23:0] glyph_x;
    logic [23:0]        glyph_y;
    logic [15:0]        line_number;
    logic               word_last;
    logic               word_truncated;
  } glw_result_t;

  // Clamp a 25-bit signed sum to the signed 24-bit range.
  function automatic logic signed [23:0] sat_s24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? S24_MIN : S24_MAX;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Clamp a 25-bit unsigned sum to the unsigned 24-bit range.
  function automatic logic [23:0] sat_u24(input logic [24:0] v);
    logic [23:0] r;
    r = v[24] ? U24_MAX : v[23:0];
    return r;
  endfunction

endpackage

@@ rtl/core/glw_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
interface glw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/glw_offset_ram.sv @@
// Glyph offset buffer of the current word: one write port, one registered read port.
module glw_offset_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [23:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [23:0] rd_data
);
  logic signed [23:0] mem [DEPTH];
  logic signed [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ rtl/core/glw_out_fifo.sv @@
// Two-entry result queue that decouples glyph emission from the result channel.
module glw_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  glw_pkg::glw_result_t push_data,
  output logic [1:0]          count,
  glw_stream_if.source        out_ch
);
  import glw_pkg::*;

  glw_result_t ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign pop            = out_ch.valid && out_ch.ready;
  assign out_ch.valid   = (cnt_r != 2'd0);
  assign out_ch.payload = ent_r[rd_ptr_r];
  assign count          = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

@@ rtl/core/greedy_word_wrap_layout.sv @@
// Greedy word-wrap layout: a printable code point is buffered unless its word
// already holds MAX_WORD_GLYPHS glyphs. A space, line feed or end of text runs
// the wrap and place states, then the emit state if the word holds glyphs; the
// offset buffer read port emits one glyph per cycle while the 2-entry result
// queue has room. Synchronous active-low reset clears the pen, line and word
// state and loads the register reset values; the offset buffer is not cleared.
module greedy_word_wrap_layout #(
  parameter int MAX_WORD_GLYPHS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  glw_stream_if.sink         in_ch,
  glw_stream_if.source       out_ch,
  input  logic               cfg_we,
  input  glw_pkg::cfg_addr_t cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import glw_pkg::*;

  localparam int CW = $clog2(MAX_WORD_GLYPHS + 1);
  localparam int AW = (MAX_WORD_GLYPHS > 1) ? $clog2(MAX_WORD_GLYPHS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRAP,
    S_PLACE,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [15:0]        line_width_r, line_height_r, line_padding_r, space_adv_r;
  logic signed [23:0] pen_x_r, pen_x_nxt;
  logic [23:0]        line_y_r, line_y_nxt;
  logic [15:0]        line_idx_r, line_idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [23:0] word_pen_r, word_pen_nxt;
  logic               ovf_r, ovf_nxt;
  logic               lf_r, lf_nxt;
  logic               eot_r, eot_nxt;

  // Placement of the word being emitted.
  logic signed [23:0] emit_x_r, emit_x_nxt;
  logic [23:0]        emit_y_r, emit_y_nxt;
  logic [15:0]        emit_line_r, emit_line_nxt;
  logic               emit_trunc_r, emit_trunc_nxt;
  logic [CW-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic [CW-1:0]      emit_idx_r, emit_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_last_r, pend_last_nxt;

  glw_item_t          item;
  logic               is_break;
  logic signed [23:0] wp_kern;
  logic signed [24:0] reach;
  logic               wrap;
  logic               ram_we;
  logic               rd_en;
  logic               issue_last;
  logic signed [23:0] rd_data;
  logic [1:0]         fifo_cnt;
  logic [2:0]         occupancy;
  glw_result_t        res;

  assign item        = in_ch.payload;
  assign in_ch.ready = (state_r == S_IDLE);
  assign is_break    = (item.char_class == CLS_SPACE) || (item.char_class == CLS_LINE_FEED);

  // Kerning joins glyphs inside a word only, never before its first glyph.
  assign wp_kern = ((cnt_r == '0) && !ovf_r) ? word_pen_r
                 : sat_s24({word_pen_r[23], word_pen_r} + 25'(item.kerning_prev));
  assign reach   = {pen_x_r[23], pen_x_r} + {word_pen_r[23], word_pen_r};
  assign wrap    = reach > $signed({9'd0, line_width_r});

  // Queue entries plus a read in flight must leave room for the next read.
  assign occupancy  = {1'b0, fifo_cnt} + {2'b00, pend_r}
                    - {2'b00, (out_ch.valid && out_ch.ready)};
  assign issue_last = (emit_idx_r == emit_cnt_r - CW'(1));

  always_comb begin
    state_nxt      = state_r;
    pen_x_nxt      = pen_x_r;
    line_y_nxt     = line_y_r;
    line_idx_nxt   = line_idx_r;
    cnt_nxt        = cnt_r;
    word_pen_nxt   = word_pen_r;
    ovf_nxt        = ovf_r;
    lf_nxt         = lf_r;
    eot_nxt        = eot_r;
    emit_x_nxt     = emit_x_r;
    emit_y_nxt     = emit_y_r;
    emit_line_nxt  = emit_line_r;
    emit_trunc_nxt = emit_trunc_r;
    emit_cnt_nxt   = emit_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    pend_nxt       = 1'b0;
    pend_last_nxt  = pend_last_r;
    ram_we         = 1'b0;
    rd_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          lf_nxt  = (item.char_class == CLS_LINE_FEED);
          eot_nxt = item.end_of_text;
          if (is_break) begin
            state_nxt = S_WRAP;
          end else begin
            if (cnt_r < CW'(MAX_WORD_GLYPHS)) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            word_pen_nxt = sat_s24({wp_kern[23], wp_kern} + {9'd0, item.glyph_advance});
            if (item.end_of_text) begin
              state_nxt = S_WRAP;
            end
          end
        end
      end

      S_WRAP: begin
        // The word's start pen is latched, then the pen moves past the word.
        if (wrap) begin
          line_y_nxt   = sat_u24({1'b0, line_y_r} + {9'd0, line_height_r});
          line_idx_nxt = (line_idx_r != LINE_INDEX_MAX) ? line_idx_r + 16'd1 : line_idx_r;
          emit_x_nxt   = '0;
          pen_x_nxt    = word_pen_r;
        end else begin
          emit_x_nxt   = pen_x_r;
          pen_x_nxt    = sat_s24(reach);
        end
        state_nxt = S_PLACE;
      end

      S_PLACE: begin
        emit_y_nxt     = sat_u24({1'b0, line_y_r} + {9'd0, line_padding_r});
        emit_line_nxt  = line_idx_r;
        emit_trunc_nxt = ovf_r;
        emit_cnt_nxt   = cnt_r;
        emit_idx_nxt   = '0;
        cnt_nxt        = '0;
        word_pen_nxt   = '0;
        ovf_nxt        = 1'b0;
        pen_x_nxt      = sat_s24({pen_x_r[23], pen_x_r} + {9'd0, space_adv_r});
        if (lf_r) begin
          line_y_nxt   = sat_u24({1'b0, line_y_r} + {9'd0, line_height_r});
          line_idx_nxt = (line_idx_r != LINE_INDEX_MAX) ? line_idx_r + 16'd1 : line_idx_r;
          pen_x_nxt    = '0;
        end
        if (eot_r) begin
          line_y_nxt   = '0;
          line_idx_nxt = '0;
          pen_x_nxt    = '0;
        end
        state_nxt = (cnt_r != '0) ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        if (occupancy < 3'd2) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = issue_last;
          emit_idx_nxt  = emit_idx_r + CW'(1);
          if (issue_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      line_width_r   <= LINE_WIDTH_RST;
      line_height_r  <= '0;
      line_padding_r <= '0;
      space_adv_r    <= '0;
      pen_x_r        <= '0;
      line_y_r       <= '0;
      line_idx_r     <= '0;
      cnt_r          <= '0;
      word_pen_r     <= '0;
      ovf_r          <= 1'b0;
      lf_r           <= 1'b0;
      eot_r          <= 1'b0;
      pend_r         <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pen_x_r    <= pen_x_nxt;
      line_y_r   <= line_y_nxt;
      line_idx_r <= line_idx_nxt;
      cnt_r      <= cnt_nxt;
      word_pen_r <= word_pen_nxt;
      ovf_r      <= ovf_nxt;
      lf_r       <= lf_nxt;
      eot_r      <= eot_nxt;
      pend_r     <= pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_WIDTH:    line_width_r   <= cfg_wdata;
          CFG_LINE_HEIGHT:   line_height_r  <= cfg_wdata;
          CFG_LINE_PADDING:  line_padding_r <= cfg_wdata;
          CFG_SPACE_ADVANCE: space_adv_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_x_r     <= emit_x_nxt;
    emit_y_r     <= emit_y_nxt;
    emit_line_r  <= emit_line_nxt;
    emit_trunc_r <= emit_trunc_nxt;
    emit_cnt_r   <= emit_cnt_nxt;
    emit_idx_r   <= emit_idx_nxt;
    pend_last_r  <= pend_last_nxt;
  end

  glw_offset_ram #(
    .DEPTH (MAX_WORD_GLYPHS),
    .AW    (AW)
  ) u_offset_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (wp_kern),
    .rd_en   (rd_en),
    .rd_addr (emit_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    res.glyph_x        = sat_s24({emit_x_r[23], emit_x_r} + {rd_data[23], rd_data});
    res.glyph_y        = emit_y_r;
    res.line_number    = emit_line_r;
    res.word_last      = pend_last_r;
    res.word_truncated = emit_trunc_r;
  end

  glw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pend_r),
    .push_data (res),
    .count     (fifo_cnt),
    .out_ch    (out_ch)
  );
endmodule
